FILE: hdl/atrp_pkg.sv
package atrp_pkg;

  // Default build options
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;

  // Fixed-point layout
  localparam int unsigned GUARD_BITS = 16;  // extra fraction bits on each sample
  localparam int unsigned HEADROOM   = 3;   // sign, CORDIC gain and sqrt(2) growth
  localparam int unsigned ZW         = 28;  // angle accumulator, Q.24 radians
  localparam int unsigned AW         = ZW - 11;  // accumulator after the Q.24 -> Q.13 shift
  localparam int unsigned ROLL_W     = 16;
  localparam int unsigned PITCH_W    = 15;
  localparam int unsigned TABLE_LEN  = 24;

  localparam int HALF_PI_Q24 = 26353589;
  localparam int GAIN_Q16    = 107922;  // round(K * 2^16), K = CORDIC gain
  localparam int ROLL_LIMIT  = 25736;
  localparam int PITCH_LIMIT = 12868;

  // atan(2^-i) in Q.24, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
    case (i)
      0:       return ZW'(13176795);
      1:       return ZW'(7778716);
      2:       return ZW'(4110060);
      3:       return ZW'(2086331);
      4:       return ZW'(1047214);
      5:       return ZW'(524117);
      6:       return ZW'(262123);
      7:       return ZW'(131069);
      8:       return ZW'(65536);
      9:       return ZW'(32768);
      10:      return ZW'(16384);
      11:      return ZW'(8192);
      12:      return ZW'(4096);
      13:      return ZW'(2048);
      14:      return ZW'(1024);
      15:      return ZW'(512);
      16:      return ZW'(256);
      17:      return ZW'(128);
      18:      return ZW'(64);
      19:      return ZW'(32);
      20:      return ZW'(16);
      21:      return ZW'(8);
      22:      return ZW'(4);
      23:      return ZW'(2);
      default: return '0;
    endcase
  endfunction

  // Round Q.24 to Q.13 (floor of z + half LSB) and clamp to +-lim
  function automatic logic signed [ROLL_W-1:0] to_q13(input logic signed [ZW-1:0] z,
                                                      input int lim);
    logic signed [ZW-1:0] s;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] hi;
    s  = z + ZW'(1024);
    a  = $signed(s[ZW-1:11]);
    hi = AW'(lim);
    if (a > hi) begin
      a = hi;
    end else if (a < -hi) begin
      a = -hi;
    end
    return a[ROLL_W-1:0];
  endfunction

endpackage

FILE: hdl/atrp_if.sv
// Gravity sample channel
interface atrp_in_if
  import atrp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] gravity_x;
  logic signed [SAMPLE_WIDTH-1:0] gravity_y;
  logic signed [SAMPLE_WIDTH-1:0] gravity_z;

  modport source (output valid, gravity_x, gravity_y, gravity_z, input ready);
  modport sink   (input valid, gravity_x, gravity_y, gravity_z, output ready);
endinterface

// Roll/pitch result channel
interface atrp_out_if
  import atrp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;

  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

FILE: hdl/atrp_prep.sv
// Entry cell: negate gy and gz, scale to guard bits, pre-rotate into the right half plane
module atrp_prep
  import atrp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned W            = SAMPLE_WIDTH_DEF + GUARD_BITS + HEADROOM
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] gx_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gy_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gz_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic signed [ZW-1:0]           z_o,
  output logic                           zero_o,
  output logic signed [SAMPLE_WIDTH-1:0] side_o
);

  logic                           valid_q;
  logic signed [W-1:0]            x_d, x_q, y_d, y_q, rx, ry;
  logic signed [ZW-1:0]           z_d, z_q;
  logic                           zero_d, zero_q;
  logic signed [SAMPLE_WIDTH-1:0] side_q;

  // roll operands: y = -gy, x = -gz, both with guard bits
  always_comb begin
    ry     = -(W'(gy_i) <<< GUARD_BITS);
    rx     = -(W'(gz_i) <<< GUARD_BITS);
    zero_d = (gy_i == '0) && (gz_i == '0);
    x_d    = rx;
    y_d    = ry;
    z_d    = '0;
    if (rx[W-1]) begin
      if (!ry[W-1]) begin
        x_d = ry;
        y_d = -rx;
        z_d = ZW'(HALF_PI_Q24);
      end else begin
        x_d = -ry;
        y_d = rx;
        z_d = -ZW'(HALF_PI_Q24);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_d;
      side_q <= gx_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign zero_o  = zero_q;
  assign side_o  = side_q;

endmodule

FILE: hdl/atrp_cell.sv
// One CORDIC vectoring iteration, registered, with its own beat valid
module atrp_cell
  import atrp_pkg::*;
#(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned W      = SAMPLE_WIDTH_DEF + GUARD_BITS + HEADROOM,
  parameter int unsigned SIDE_W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  input  logic signed [ZW-1:0]    z_i,
  input  logic                    zero_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [W-1:0]     x_o,
  output logic signed [W-1:0]     y_o,
  output logic signed [ZW-1:0]    z_o,
  output logic                    zero_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q24(STAGE);

  logic                 valid_q;
  logic signed [W-1:0]  xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic                 zero_q;
  logic [SIDE_W-1:0]    side_q;

  // rotate toward y = 0; the zero vector keeps its angle at zero
  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[W-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = zero_i ? z_i : z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = zero_i ? z_i : z_i - ATAN;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign zero_o  = zero_q;
  assign side_o  = side_q;

endmodule

FILE: hdl/atrp_link.sv
// Between the chains: finish roll, scale gx by the CORDIC gain, seed the pitch vector
module atrp_link
  import atrp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned W            = SAMPLE_WIDTH_DEF + GUARD_BITS + HEADROOM
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [W-1:0]            mag_i,
  input  logic signed [ZW-1:0]           roll_z_i,
  input  logic                           zero_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gx_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic signed [ZW-1:0]           z_o,
  output logic                           zero_o,
  output logic [ROLL_W-1:0]              side_o
);

  logic                     valid_q;
  logic signed [W-1:0]      x_q, y_q, py;
  logic                     zero_q;
  logic [ROLL_W-1:0]        roll_q;

  // magnitude is never negative, so the pitch vector needs no pre-rotation
  assign py = W'(gx_i) * W'(GAIN_Q16);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= mag_i;
      y_q    <= py;
      zero_q <= zero_i && (gx_i == '0);
      roll_q <= to_q13(roll_z_i, ROLL_LIMIT);
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = '0;
  assign zero_o  = zero_q;
  assign side_o  = roll_q;

endmodule

FILE: hdl/accel_tilt_roll_pitch_core.sv
// Channel   Dir  Beat contents
// sample_i  in   gravity_x, gravity_y, gravity_z (signed, SAMPLE_WIDTH bits)
// angle_o   out  roll_angle (Q3.13, 16 bits), pitch_angle (Q2.13, 15 bits)
//
// One sample per cycle while angle_o is ready; each sample passes, in order, the
// entry cell, roll CORDIC cells, link cell with the gain multiply, pitch CORDIC
// cells and output register. Each cell holds one beat and its own valid,
// so a stall on angle_o fills empty cells before sample_i.ready drops.
// Reset clears only the valid bits; the data registers are not reset.
module accel_tilt_roll_pitch_core
  import atrp_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atrp_in_if.sink     sample_i,
  atrp_out_if.source  angle_o
);

  localparam int unsigned W = SAMPLE_WIDTH + GUARD_BITS + HEADROOM;

  // roll chain taps
  logic                           r_valid [CORDIC_STAGES+1];
  logic                           r_ready [CORDIC_STAGES+1];
  logic signed [W-1:0]            r_x     [CORDIC_STAGES+1];
  logic signed [W-1:0]            r_y     [CORDIC_STAGES+1];
  logic signed [ZW-1:0]           r_z     [CORDIC_STAGES+1];
  logic                           r_zero  [CORDIC_STAGES+1];
  logic [SAMPLE_WIDTH-1:0]        r_side  [CORDIC_STAGES+1];

  // pitch chain taps
  logic                           p_valid [CORDIC_STAGES+1];
  logic                           p_ready [CORDIC_STAGES+1];
  logic signed [W-1:0]            p_x     [CORDIC_STAGES+1];
  logic signed [W-1:0]            p_y     [CORDIC_STAGES+1];
  logic signed [ZW-1:0]           p_z     [CORDIC_STAGES+1];
  logic                           p_zero  [CORDIC_STAGES+1];
  logic [ROLL_W-1:0]              p_side  [CORDIC_STAGES+1];

  logic                           out_valid_q;
  logic signed [ROLL_W-1:0]       roll_q;
  logic signed [PITCH_W-1:0]      pitch_q;
  logic signed [ROLL_W-1:0]       pitch_full;

  // entry cell
  atrp_prep #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .W            (W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sample_i.valid),
    .ready_o (sample_i.ready),
    .gx_i    (sample_i.gravity_x),
    .gy_i    (sample_i.gravity_y),
    .gz_i    (sample_i.gravity_z),
    .valid_o (r_valid[0]),
    .ready_i (r_ready[0]),
    .x_o     (r_x[0]),
    .y_o     (r_y[0]),
    .z_o     (r_z[0]),
    .zero_o  (r_zero[0]),
    .side_o  (r_side[0])
  );

  // roll: atan2(-gy, -gz), final x is the scaled magnitude
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_roll
    atrp_cell #(
      .STAGE  (k),
      .W      (W),
      .SIDE_W (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (r_valid[k]),
      .ready_o (r_ready[k]),
      .x_i     (r_x[k]),
      .y_i     (r_y[k]),
      .z_i     (r_z[k]),
      .zero_i  (r_zero[k]),
      .side_i  (r_side[k]),
      .valid_o (r_valid[k+1]),
      .ready_i (r_ready[k+1]),
      .x_o     (r_x[k+1]),
      .y_o     (r_y[k+1]),
      .z_o     (r_z[k+1]),
      .zero_o  (r_zero[k+1]),
      .side_o  (r_side[k+1])
    );
  end

  atrp_link #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .W            (W)
  ) u_link (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (r_valid[CORDIC_STAGES]),
    .ready_o  (r_ready[CORDIC_STAGES]),
    .mag_i    (r_x[CORDIC_STAGES]),
    .roll_z_i (r_z[CORDIC_STAGES]),
    .zero_i   (r_zero[CORDIC_STAGES]),
    .gx_i     ($signed(r_side[CORDIC_STAGES])),
    .valid_o  (p_valid[0]),
    .ready_i  (p_ready[0]),
    .x_o      (p_x[0]),
    .y_o      (p_y[0]),
    .z_o      (p_z[0]),
    .zero_o   (p_zero[0]),
    .side_o   (p_side[0])
  );

  // pitch: atan2(gx*K, K*|(gy,gz)|), roll angle rides along
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_pitch
    atrp_cell #(
      .STAGE  (k),
      .W      (W),
      .SIDE_W (ROLL_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p_valid[k]),
      .ready_o (p_ready[k]),
      .x_i     (p_x[k]),
      .y_i     (p_y[k]),
      .z_i     (p_z[k]),
      .zero_i  (p_zero[k]),
      .side_i  (p_side[k]),
      .valid_o (p_valid[k+1]),
      .ready_i (p_ready[k+1]),
      .x_o     (p_x[k+1]),
      .y_o     (p_y[k+1]),
      .z_o     (p_z[k+1]),
      .zero_o  (p_zero[k+1]),
      .side_o  (p_side[k+1])
    );
  end

  // output register
  assign pitch_full               = to_q13(p_z[CORDIC_STAGES], PITCH_LIMIT);
  assign p_ready[CORDIC_STAGES]   = !out_valid_q || angle_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_ready[CORDIC_STAGES]) begin
      out_valid_q <= p_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid[CORDIC_STAGES] && p_ready[CORDIC_STAGES]) begin
      roll_q  <= $signed(p_side[CORDIC_STAGES]);
      pitch_q <= pitch_full[PITCH_W-1:0];
    end
  end

  assign angle_o.valid       = out_valid_q;
  assign angle_o.roll_angle  = roll_q;
  assign angle_o.pitch_angle = pitch_q;

  // checks
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_o.valid |-> (roll_q <= 16'sd25736) && (roll_q >= -16'sd25736))
    else $error("roll angle out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_o.valid |-> (pitch_q <= 15'sd12868) && (pitch_q >= -15'sd12868))
    else $error("pitch angle out of range");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !angle_o.valid |-> sample_i.ready)
    else $error("input stalled while output register is empty");

  a_link_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid[0] && p_zero[0]) |-> (p_side[0] == '0) && (p_x[0] == '0))
    else $error("zero vector produced nonzero roll or magnitude");

endmodule

FILE: tb/tb_accel_tilt_roll_pitch_core.sv
module tb_accel_tilt_roll_pitch_core;
  timeunit 1ns;
  timeprecision 1ps;

  import atrp_pkg::*;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STAGES   = 16;
  localparam int RANDOM_COUNT     = 1580;
  localparam int DRAIN_AT         = 800;   // random sample that waits for an empty pipe
  localparam int HOLD_AFTER       = 400;   // results seen before the long output stall
  localparam int HOLD_CYCLES      = 200;
  localparam int SETTLE_CYCLES    = 2 * STAGES + 30;
  localparam int WATCHDOG_LIMIT   = 3000;

  // atan(2^-i) in Q.24
  localparam longint ARCTAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] gx;
    logic signed [SAMPLE_W-1:0] gy;
    logic signed [SAMPLE_W-1:0] gz;
    bit                         drain_first;
  } sample_t;

  typedef struct {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
  } angle_t;

  logic clk;
  logic rst_n;

  atrp_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_if ();
  atrp_out_if angle_if ();

  accel_tilt_roll_pitch_core #(
    .CORDIC_STAGES(STAGES),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_if),
    .angle_o (angle_if)
  );

  sample_t pending_samples[$];
  angle_t  expected_angles[$];
  sample_t drive_sample;
  angle_t  want_angle;

  int  mismatch_count = 0;
  int  samples_sent   = 0;
  int  results_seen   = 0;
  int  send_gap;
  int  recv_stall;
  int  long_hold;
  bit  hold_done;
  bit  sample_taken;
  bit  result_taken;
  int  idle_cycles    = 0;

  // CORDIC vectoring of (x, y): angle in Q.24, final x through mag
  function automatic longint vector_angle(input longint y_in, input longint x_in,
                                          output longint mag);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    int     i;
    x   = x_in;
    y   = y_in;
    z   = 0;
    mag = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    // fold the left half plane onto the right one
    if (x < 0) begin
      xs = x;
      if (y >= 0) begin
        x = y;
        y = -xs;
        z = HALF_PI_Q24;
      end else begin
        x = -y;
        y = xs;
        z = -HALF_PI_Q24;
      end
    end
    for (i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q24[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q24[i];
      end
    end
    mag = x;
    return z;
  endfunction

  // Q.24 -> Q3.13 with round half up, then clamp
  function automatic longint round_clamp(input longint z, input longint lim);
    longint a;
    a = (z + 1024) >>> 11;
    if (a > lim) begin
      a = lim;
    end else if (a < -lim) begin
      a = -lim;
    end
    return a;
  endfunction

  function automatic angle_t tilt_angles(input sample_t s);
    angle_t r;
    longint gx;
    longint gy;
    longint gz;
    longint mag;
    longint spare;
    longint roll;
    longint pitch;
    gx    = s.gx;
    gy    = s.gy;
    gz    = s.gz;
    roll  = round_clamp(vector_angle(-gy * (longint'(1) << GUARD_BITS),
                                     -gz * (longint'(1) << GUARD_BITS), mag), ROLL_LIMIT);
    // magnitude already carries the CORDIC gain, so scale gx to match
    pitch = round_clamp(vector_angle(gx * GAIN_Q16, mag, spare), PITCH_LIMIT);
    r.roll  = ROLL_W'(roll);
    r.pitch = PITCH_W'(pitch);
    return r;
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic int rnd_span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic push_sample(input int x, input int y, input int z, input bit drain);
    sample_t s;
    s.gx          = SAMPLE_W'(x);
    s.gy          = SAMPLE_W'(y);
    s.gz          = SAMPLE_W'(z);
    s.drain_first = drain;
    pending_samples.push_back(s);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample driver: changes on the falling edge
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      sample_if.valid     <= 1'b0;
      sample_if.gravity_x <= '0;
      sample_if.gravity_y <= '0;
      sample_if.gravity_z <= '0;
      send_gap            <= 0;
    end else if (sample_if.valid && !sample_taken) begin
      // beat still waiting for ready
    end else if (send_gap > 0) begin
      sample_if.valid <= 1'b0;
      send_gap        <= send_gap - 1;
    end else if (pending_samples.size() != 0 &&
                 !(pending_samples[0].drain_first && expected_angles.size() != 0)) begin
      drive_sample         = pending_samples.pop_front();
      sample_if.gravity_x <= drive_sample.gx;
      sample_if.gravity_y <= drive_sample.gy;
      sample_if.gravity_z <= drive_sample.gz;
      sample_if.valid     <= 1'b1;
      send_gap            <= draw_wait(((samples_sent / 128) % 4) == 3);
    end else begin
      sample_if.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      angle_if.ready <= 1'b0;
      recv_stall      = 0;
      long_hold      <= 0;
      hold_done      <= 1'b0;
    end else if (long_hold > 0) begin
      angle_if.ready <= 1'b0;
      long_hold      <= long_hold - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      angle_if.ready <= 1'b0;
      long_hold      <= HOLD_CYCLES;
      hold_done      <= 1'b1;
    end else if (angle_if.ready && result_taken) begin
      recv_stall = draw_wait(((results_seen / 128) % 4) == 1);
      if (recv_stall > 0) begin
        angle_if.ready <= 1'b0;
        recv_stall      = recv_stall - 1;
      end
    end else if (angle_if.ready) begin
      // keep waiting for a beat
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
    end else begin
      angle_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted samples, check accepted results
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      sample_taken <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      sample_taken <= sample_if.valid && sample_if.ready;
      result_taken <= angle_if.valid && angle_if.ready;
      if (sample_if.valid && sample_if.ready) begin
        drive_sample.gx = sample_if.gravity_x;
        drive_sample.gy = sample_if.gravity_y;
        drive_sample.gz = sample_if.gravity_z;
        expected_angles.push_back(tilt_angles(drive_sample));
        samples_sent++;
      end
      if (angle_if.valid && angle_if.ready) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected beat, roll %0d pitch %0d", $time,
                   angle_if.roll_angle, angle_if.pitch_angle);
          mismatch_count++;
        end else begin
          want_angle = expected_angles.pop_front();
          if (angle_if.roll_angle !== want_angle.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time,
                     want_angle.roll, angle_if.roll_angle);
            mismatch_count++;
          end
          if (angle_if.pitch_angle !== want_angle.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time,
                     want_angle.pitch, angle_if.pitch_angle);
            mismatch_count++;
          end
        end
        results_seen++;
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((sample_if.valid && sample_if.ready) || (angle_if.valid && angle_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    int kind;
    int axis;
    int big;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero vector, axis extremes, both pre-rotation sides, clamps
    push_sample(0, 0, 0, 1'b0);
    push_sample(0, 0, -16384, 1'b0);
    push_sample(0, 0, 16384, 1'b0);
    push_sample(0, 0, -32768, 1'b0);
    push_sample(0, 0, 32767, 1'b0);
    push_sample(0, -32768, 0, 1'b0);
    push_sample(0, 32767, 0, 1'b0);
    push_sample(-32768, 0, 0, 1'b0);
    push_sample(32767, 0, 0, 1'b0);
    push_sample(-32768, -32768, -32768, 1'b0);
    push_sample(32767, 32767, 32767, 1'b0);
    push_sample(-32768, 32767, -32768, 1'b0);
    push_sample(0, -50, 100, 1'b0);
    push_sample(0, 50, 100, 1'b0);
    push_sample(0, 1, 32767, 1'b0);
    push_sample(0, -1, 32767, 1'b0);
    push_sample(1, 0, 0, 1'b0);
    push_sample(-1, 0, 0, 1'b0);
    push_sample(0, 0, 1, 1'b0);
    push_sample(-1, -1, -1, 1'b0);
    push_sample(1000, -2000, 3000, 1'b0);
    push_sample(-12000, 9000, -7000, 1'b0);

    // Random: full range, near-gravity with one dominant axis, small, degenerate planes
    for (n = 0; n < RANDOM_COUNT; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          push_sample(int'($urandom()) % 65536, int'($urandom()) % 65536,
                      int'($urandom()) % 65536, n == DRAIN_AT);
        end
        3, 4, 5: begin
          axis = $urandom_range(0, 2);
          big  = rnd_span(32767);
          push_sample(axis == 0 ? big : rnd_span(300), axis == 1 ? big : rnd_span(300),
                      axis == 2 ? big : rnd_span(300), n == DRAIN_AT);
        end
        6: begin
          push_sample(rnd_span(8), rnd_span(8), rnd_span(8), n == DRAIN_AT);
        end
        7: begin
          // roll lands exactly on zero or the pi clamp
          push_sample(rnd_span(32767), 0, rnd_span(32767), n == DRAIN_AT);
        end
        8: begin
          // no y/z magnitude: pitch pinned at +-pi/2
          push_sample(rnd_span(32767), 0, 0, n == DRAIN_AT);
        end
        default: begin
          push_sample(rnd_span(2000), rnd_span(2000), rnd_span(2000), n == DRAIN_AT);
        end
      endcase
    end

    while (pending_samples.size() != 0 || sample_if.valid || expected_angles.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
